### hdl/sime_pkg.sv
package sime_pkg;

  // Working width of the datapath: intermediates are 64-bit values, most of them kept by saturating adds.
  localparam int XW = 64;

  // Register stages from input capture to the output register.
  localparam int NSTG = 9;

  localparam int POSITION_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_START = 3'd1;
  localparam logic [2:0] CFG_END   = 3'd2;
  localparam logic [2:0] CFG_COUNT = 3'd3;
  localparam logic [2:0] CFG_SCALE = 3'd4;

  // Edit modes
  localparam logic [1:0] MODE_CLIP   = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;
  localparam logic [1:0] MODE_SCALE  = 2'd3;

  // Q16.16 unity
  localparam logic [31:0] SCALE_ONE = 32'h0001_0000;

  typedef logic signed [XW-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(XW-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(XW-1){1'b0}}};

  typedef struct packed {
    logic  keep;
    word_t pos;
    word_t ext;
  } res_t;

  // Saturating add
  function automatic word_t sadd(word_t a, word_t b);
    logic [XW:0] sum;
    sum = {a[XW-1], a} + {b[XW-1], b};
    if (sum[XW] != sum[XW-1]) begin
      sadd = sum[XW] ? WORD_MIN : WORD_MAX;
    end else begin
      sadd = word_t'(sum[XW-1:0]);
    end
  endfunction

  // Saturating subtract
  function automatic word_t ssub(word_t a, word_t b);
    logic [XW:0] dif;
    dif = {a[XW-1], a} - {b[XW-1], b};
    if (dif[XW] != dif[XW-1]) begin
      ssub = dif[XW] ? WORD_MIN : WORD_MAX;
    end else begin
      ssub = word_t'(dif[XW-1:0]);
    end
  endfunction

  // Largest value of a signed field of the given width, in the working width
  function automatic word_t pos_max(int bits);
    logic [XW-1:0] one;
    one = {{(XW-1){1'b0}}, 1'b1};
    pos_max = word_t'((one << (bits - 1)) - one);
  endfunction

endpackage

### hdl/sime_flow.sv
module sime_flow (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        out_stall,
  output logic                        in_stall,
  output logic [sime_pkg::NSTG:1]     ld,
  output logic                        out_valid
);

  logic [sime_pkg::NSTG:1] valid_r;
  logic [sime_pkg::NSTG:1] valid_nxt;
  logic [sime_pkg::NSTG:1] rdy;
  logic [sime_pkg::NSTG:1] src;
  logic                    acc_in;
  logic                    acc_out;

  // A stage takes new data when it is empty or the stage after it moves.
  always_comb begin
    rdy[sime_pkg::NSTG] = !valid_r[sime_pkg::NSTG] || !out_stall;
    for (int k = sime_pkg::NSTG - 1; k >= 1; k--) begin
      rdy[k] = !valid_r[k] || rdy[k+1];
    end
  end

  assign src       = {valid_r[sime_pkg::NSTG-1:1], in_valid};
  assign valid_nxt = (rdy & src) | (~rdy & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ld        = rdy;
  assign in_stall  = !rdy[1];
  assign out_valid = valid_r[sime_pkg::NSTG];
  assign acc_in    = in_valid && !in_stall;
  assign acc_out   = out_valid && !out_stall;

  // Input backs up only when every stage is full and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&valid_r) && out_stall))
    else $error("input stalled with a bubble in the pipeline");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in |=> valid_r[1])
    else $error("accepted transaction not in first stage");

  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[sime_pkg::NSTG-1] && !rdy[sime_pkg::NSTG])
      |=> (valid_r[sime_pkg::NSTG-1] && valid_r[sime_pkg::NSTG]))
    else $error("held stage lost its transaction");

  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r) ==
              $past($countones(valid_r)) + $past(acc_in) - $past(acc_out)))
    else $error("transaction count in pipeline is not conserved");

endmodule

### hdl/sime_scale.sv
module sime_scale #(
  parameter int POSITION_BITS = sime_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk,
  input  logic [2:0]                ld,
  input  logic                      neg,
  input  logic [sime_pkg::XW-1:0]   mag,
  input  logic [31:0]               factor,
  output sime_pkg::word_t           result
);

  localparam sime_pkg::word_t PHI = sime_pkg::pos_max(POSITION_BITS);
  localparam sime_pkg::word_t PLO = ~PHI;

  logic                    neg_a_r;
  logic [63:0]             plow_r;
  logic [63:0]             phigh_r;
  logic                    neg_b_r;
  logic                    ovf_r;
  logic [63:0]             sum_r;
  logic [63:0]             sum_nxt;
  sime_pkg::word_t         result_r;
  sime_pkg::word_t         result_nxt;

  // Round half away from zero: add half an LSB before dropping 16 fraction bits.
  assign sum_nxt = (phigh_r << 16) + ((plow_r + 64'h0000_0000_0000_8000) >> 16);

  always_comb begin
    if (ovf_r || (sum_r > $unsigned(PHI))) begin
      result_nxt = neg_b_r ? PLO : PHI;
    end else begin
      result_nxt = neg_b_r ? sime_pkg::word_t'(64'd0 - sum_r) : sime_pkg::word_t'(sum_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      neg_a_r <= neg;
      plow_r  <= mag[31:0] * factor;
      phigh_r <= mag[63:32] * factor;
    end
    if (ld[1]) begin
      neg_b_r <= neg_a_r;
      ovf_r   <= |phigh_r[63:47];
      sum_r   <= sum_nxt;
    end
    if (ld[2]) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

### hdl/sime_delete.sv
module sime_delete (
  input  logic              clk,
  input  logic [5:0]        ld,
  input  sime_pkg::word_t   pos,
  input  sime_pkg::word_t   ext,
  input  sime_pkg::word_t   end_fwd,
  input  sime_pkg::word_t   end_bwd,
  input  sime_pkg::word_t   reg_start,
  input  sime_pkg::word_t   cnt_m1,
  input  sime_pkg::word_t   cnt_mag,
  input  logic              cnt_zero,
  output sime_pkg::res_t    result
);

  typedef struct packed {
    sime_pkg::word_t t;
    sime_pkg::word_t s;
    sime_pkg::word_t a;
    sime_pkg::word_t b;
    sime_pkg::word_t n;
    logic            nz;
    sime_pkg::word_t lo;
    sime_pkg::word_t hi;
    sime_pkg::word_t len;
    logic            alo;
    logic            bhi;
    logic            blo;
    logic            ahi;
    logic            pa;
    logic            pb;
    sime_pkg::word_t x1;
    sime_pkg::word_t x2;
    sime_pkg::word_t pn;
    sime_pkg::word_t y1;
    sime_pkg::word_t y2;
    sime_pkg::word_t len1;
    sime_pkg::word_t len2;
    sime_pkg::word_t nl1;
    sime_pkg::word_t nl2;
    sime_pkg::word_t q;
    logic            z2;
  } dl_t;

  localparam sime_pkg::word_t ONE  = sime_pkg::word_t'(1);
  localparam sime_pkg::word_t ZERO = '0;

  dl_t             st_r [0:4];
  dl_t             st0_nxt;
  dl_t             st1_nxt;
  dl_t             st2_nxt;
  dl_t             st3_nxt;
  dl_t             st4_nxt;
  sime_pkg::res_t  res_r;
  sime_pkg::res_t  res_nxt;

  always_comb begin
    // region end and the covered interval of the mark
    st0_nxt    = '0;
    st0_nxt.t  = pos;
    st0_nxt.s  = ext;
    st0_nxt.a  = reg_start;
    st0_nxt.b  = sime_pkg::sadd(reg_start, cnt_m1);
    st0_nxt.n  = cnt_mag;
    st0_nxt.nz = cnt_zero;
    if (ext > ZERO) begin
      st0_nxt.lo  = pos;
      st0_nxt.hi  = end_fwd;
      st0_nxt.len = ext;
    end else begin
      st0_nxt.lo  = end_bwd;
      st0_nxt.hi  = pos;
      st0_nxt.len = sime_pkg::ssub(ZERO, ext);
    end

    // overlap tests and first differences
    st1_nxt     = st_r[0];
    st1_nxt.alo = st_r[0].a < st_r[0].lo;
    st1_nxt.bhi = st_r[0].b >= st_r[0].hi;
    st1_nxt.blo = st_r[0].b < st_r[0].lo;
    st1_nxt.ahi = st_r[0].a <= st_r[0].hi;
    st1_nxt.pa  = st_r[0].t >= st_r[0].a;
    st1_nxt.pb  = st_r[0].t <= st_r[0].b;
    st1_nxt.x1  = sime_pkg::ssub(st_r[0].b, st_r[0].lo);
    st1_nxt.x2  = sime_pkg::ssub((st_r[0].b > st_r[0].hi) ? st_r[0].hi : st_r[0].b,
                                 st_r[0].a);
    st1_nxt.pn  = sime_pkg::ssub(st_r[0].t, st_r[0].n);

    // overlap lengths
    st2_nxt    = st_r[1];
    st2_nxt.y1 = sime_pkg::sadd(st_r[1].x1, ONE);
    st2_nxt.y2 = sime_pkg::sadd(st_r[1].x2, ONE);

    // remaining span lengths
    st3_nxt      = st_r[2];
    st3_nxt.len1 = sime_pkg::ssub(st_r[2].len, st_r[2].y1);
    st3_nxt.len2 = sime_pkg::ssub(st_r[2].len, st_r[2].y2);

    // negated lengths and anchor shift of a backward span cut from inside
    st4_nxt     = st_r[3];
    st4_nxt.nl1 = sime_pkg::ssub(ZERO, st_r[3].len1);
    st4_nxt.nl2 = sime_pkg::ssub(ZERO, st_r[3].len2);
    st4_nxt.q   = sime_pkg::sadd(st_r[3].len2, st_r[3].s);
    st4_nxt.z2  = st_r[3].len2 == ZERO;
  end

  always_comb begin
    res_nxt.keep = 1'b1;
    res_nxt.pos  = st_r[4].t;
    res_nxt.ext  = st_r[4].s;
    if (st_r[4].nz) begin
      res_nxt.keep = 1'b1;
    end else if (st_r[4].s == ZERO) begin
      if (st_r[4].pa && st_r[4].pb) begin
        res_nxt.keep = 1'b0;
      end else if (st_r[4].pa) begin
        res_nxt.pos = st_r[4].pn;
      end
    end else if (st_r[4].alo) begin
      // region starts before the mark
      if (st_r[4].bhi) begin
        res_nxt.keep = 1'b0;
      end else if (st_r[4].blo) begin
        res_nxt.pos = st_r[4].pn;
      end else if (st_r[4].s > ZERO) begin
        res_nxt.ext = st_r[4].len1;
        res_nxt.pos = st_r[4].a;
      end else begin
        res_nxt.ext = st_r[4].nl1;
        res_nxt.pos = st_r[4].pn;
      end
    end else if (st_r[4].ahi) begin
      // region starts inside the mark
      if (st_r[4].z2) begin
        res_nxt.keep = 1'b0;
      end else if (st_r[4].s > ZERO) begin
        res_nxt.ext = st_r[4].len2;
      end else begin
        res_nxt.ext = st_r[4].nl2;
        res_nxt.pos = sime_pkg::sadd(st_r[4].t, st_r[4].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) st_r[0] <= st0_nxt;
    if (ld[1]) st_r[1] <= st1_nxt;
    if (ld[2]) st_r[2] <= st2_nxt;
    if (ld[3]) st_r[3] <= st3_nxt;
    if (ld[4]) st_r[4] <= st4_nxt;
    if (ld[5]) res_r   <= res_nxt;
  end

  assign result = res_r;

endmodule

### hdl/signed_interval_mark_editor_unit.sv
// Mark editor: one time mark in, one edited mark out.
//
// Input channel (in_valid / in_stall) carries a mark: anchor position and
// signed span. Result channel (out_valid / out_stall) returns the keep flag
// and the edited anchor and span, saturated to POSITION_BITS. A transaction
// moves at a clock edge where valid is high and stall is low.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata):
// mode, start, end, count and the Q16.16 scale factor. Write it only while
// no mark is in flight.
// Throughput: one mark per cycle while out_stall is low. Depth: nine register
// stages, from the input capture register to the output register. The depth
// is set by the delete path, a chain of saturating 64-bit adds cut into one
// add per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// register defaults: clip mode, zero window and count, unity scale.
// When the receiver stalls, the output register holds its mark and earlier
// stages keep moving until they are full; in_stall rises only when every
// stage holds a mark.
module signed_interval_mark_editor_unit #(
  parameter  int POSITION_BITS = sime_pkg::POSITION_BITS_DEF,
  localparam int CFG_W = (POSITION_BITS > 32) ? POSITION_BITS : 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [POSITION_BITS-1:0] in_mark_position,
  input  logic signed [POSITION_BITS-1:0] in_mark_extent,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_keep_mark,
  output logic signed [POSITION_BITS-1:0] out_new_position,
  output logic signed [POSITION_BITS-1:0] out_new_extent,
  input  logic                            cfg_wr_en,
  input  logic [2:0]                      cfg_index,
  input  logic [CFG_W-1:0]                cfg_wdata
);

  localparam sime_pkg::word_t PHI  = sime_pkg::pos_max(POSITION_BITS);
  localparam sime_pkg::word_t PLO  = ~PHI;
  localparam sime_pkg::word_t ONE  = sime_pkg::word_t'(1);
  localparam sime_pkg::word_t ZERO = '0;
  localparam int              LAST = sime_pkg::NSTG - 1;

  // clip span fix-up codes
  localparam logic [1:0] CLIP_HOLD = 2'd0;
  localparam logic [1:0] CLIP_INC  = 2'd1;
  localparam logic [1:0] CLIP_DEC  = 2'd2;

  typedef struct packed {
    sime_pkg::word_t t;
    sime_pkg::word_t s;
    sime_pkg::word_t ttp;
    sime_pkg::word_t ttn;
    sime_pkg::word_t nmag;
    sime_pkg::word_t nm1;
    sime_pkg::word_t a_d;
    logic            nz;
    logic            dn;
    logic [63:0]     dm;
    logic            eneg;
    logic [63:0]     emag;
  } prep_t;

  typedef struct packed {
    logic            keep;
    sime_pkg::word_t pos;
    sime_pkg::word_t dif;
    logic [1:0]      op;
  } clip_t;

  // configuration
  logic [1:0]                     edit_mode_r;
  logic signed [POSITION_BITS-1:0] edit_start_r;
  logic signed [POSITION_BITS-1:0] edit_end_r;
  logic signed [POSITION_BITS-1:0] edit_count_r;
  logic [31:0]                    scale_factor_r;

  logic [sime_pkg::NSTG:1] ld;

  sime_pkg::word_t t0;
  sime_pkg::word_t t1;
  sime_pkg::word_t cnt;

  sime_pkg::word_t p1_r;
  sime_pkg::word_t s1_r;
  prep_t           prep_r;
  prep_t           prep_nxt;
  clip_t           clip3_r;
  clip_t           clip3_nxt;
  sime_pkg::res_t  clip4_nxt;
  sime_pkg::res_t  ins3_nxt;
  sime_pkg::res_t  clip_r [4:LAST];
  sime_pkg::res_t  ins_r  [3:LAST];
  sime_pkg::res_t  scl_r  [6:LAST];
  sime_pkg::word_t scl_pos;
  sime_pkg::word_t scl_ext;
  sime_pkg::res_t  del_res;
  sime_pkg::res_t  sel;

  logic                            out_keep_mark_r;
  logic signed [POSITION_BITS-1:0] out_new_position_r;
  logic signed [POSITION_BITS-1:0] out_new_extent_r;
  logic                            keep_nxt;
  sime_pkg::word_t                 pos_nxt;
  sime_pkg::word_t                 ext_nxt;

  function automatic sime_pkg::word_t clampp(sime_pkg::word_t v);
    if (v > PHI) begin
      clampp = PHI;
    end else if (v < PLO) begin
      clampp = PLO;
    end else begin
      clampp = v;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_mode_r    <= sime_pkg::MODE_CLIP;
      edit_start_r   <= '0;
      edit_end_r     <= '0;
      edit_count_r   <= '0;
      scale_factor_r <= sime_pkg::SCALE_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        sime_pkg::CFG_MODE:  edit_mode_r    <= cfg_wdata[1:0];
        sime_pkg::CFG_START: edit_start_r   <= cfg_wdata[POSITION_BITS-1:0];
        sime_pkg::CFG_END:   edit_end_r     <= cfg_wdata[POSITION_BITS-1:0];
        sime_pkg::CFG_COUNT: edit_count_r   <= cfg_wdata[POSITION_BITS-1:0];
        sime_pkg::CFG_SCALE: scale_factor_r <= cfg_wdata[31:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  assign t0  = sime_pkg::word_t'(edit_start_r);
  assign t1  = sime_pkg::word_t'(edit_end_r);
  assign cnt = sime_pkg::word_t'(edit_count_r);

  // ---------------------------------------------------------------------------
  // Handshake and stage enables
  // ---------------------------------------------------------------------------
  sime_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ld        (ld),
    .out_valid (out_valid)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: span ends, normalized count, scale magnitudes
  // ---------------------------------------------------------------------------
  always_comb begin
    prep_nxt      = '0;
    prep_nxt.t    = p1_r;
    prep_nxt.s    = s1_r;
    // last sample of a forward span, first sample of a backward span
    prep_nxt.ttp  = sime_pkg::sadd(p1_r, s1_r - ONE);
    prep_nxt.ttn  = sime_pkg::sadd(p1_r, s1_r + ONE);
    prep_nxt.nz   = cnt == ZERO;
    if (cnt < ZERO) begin
      // a backward delete ends at the start register
      prep_nxt.nmag = sime_pkg::ssub(ZERO, cnt);
      prep_nxt.nm1  = (cnt == sime_pkg::WORD_MIN) ? (sime_pkg::WORD_MAX - ONE) : ~cnt;
      prep_nxt.a_d  = sime_pkg::ssub(t0, prep_nxt.nm1);
    end else begin
      prep_nxt.nmag = cnt;
      prep_nxt.nm1  = cnt - ONE;
      prep_nxt.a_d  = t0;
    end
    prep_nxt.dn   = p1_r < t0;
    prep_nxt.dm   = prep_nxt.dn ? $unsigned(t0 - p1_r) : $unsigned(p1_r - t0);
    prep_nxt.eneg = s1_r < ZERO;
    prep_nxt.emag = prep_nxt.eneg ? $unsigned(ZERO - s1_r) : $unsigned(s1_r);
  end

  // ---------------------------------------------------------------------------
  // Stage 3: clip decision, insert result
  // ---------------------------------------------------------------------------
  always_comb begin
    clip3_nxt.keep = 1'b1;
    clip3_nxt.pos  = prep_r.t;
    clip3_nxt.dif  = prep_r.s;
    clip3_nxt.op   = CLIP_HOLD;
    if (prep_r.s == ZERO) begin
      clip3_nxt.keep = !(prep_r.t < t0 || prep_r.t > t1);
    end else if (prep_r.s > ZERO) begin
      if (prep_r.ttp < t0 || prep_r.t > t1) begin
        clip3_nxt.keep = 1'b0;
      end else if (prep_r.t < t0) begin
        // trim the head, and the tail too when it runs past the window
        clip3_nxt.pos = t0;
        clip3_nxt.dif = sime_pkg::ssub((prep_r.ttp > t1) ? t1 : prep_r.ttp, t0);
        clip3_nxt.op  = CLIP_INC;
      end else if (prep_r.ttp > t1) begin
        clip3_nxt.dif = sime_pkg::ssub(t1, prep_r.t);
        clip3_nxt.op  = CLIP_INC;
      end
    end else begin
      if (prep_r.t < t0 || prep_r.ttn > t1) begin
        clip3_nxt.keep = 1'b0;
      end else if (prep_r.t > t1) begin
        // anchor past the window end moves onto the end
        clip3_nxt.pos = t1;
        clip3_nxt.dif = sime_pkg::ssub((prep_r.ttn < t0) ? t0 : prep_r.ttn, t1);
        clip3_nxt.op  = CLIP_DEC;
      end else if (prep_r.ttn < t0) begin
        clip3_nxt.dif = sime_pkg::ssub(t0, prep_r.t);
        clip3_nxt.op  = CLIP_DEC;
      end
    end
  end

  always_comb begin
    ins3_nxt.keep = 1'b1;
    ins3_nxt.pos  = prep_r.t;
    ins3_nxt.ext  = prep_r.s;
    if (!prep_r.nz) begin
      if (prep_r.s == ZERO) begin
        if (prep_r.t >= prep_r.a_d || prep_r.t >= t0) begin
          ins3_nxt.pos = (prep_r.t >= t0) ? sime_pkg::sadd(prep_r.t, prep_r.nmag) : prep_r.t;
        end
      end else if (prep_r.s > ZERO) begin
        if (t0 <= prep_r.t) begin
          ins3_nxt.pos = sime_pkg::sadd(prep_r.t, prep_r.nmag);
        end else if (t0 < prep_r.ttp) begin
          ins3_nxt.ext = sime_pkg::sadd(prep_r.s, prep_r.nmag);
        end
      end else begin
        if (t0 <= prep_r.ttn) begin
          ins3_nxt.pos = sime_pkg::sadd(prep_r.t, prep_r.nmag);
        end else if (t0 < prep_r.t) begin
          ins3_nxt.ext = sime_pkg::ssub(prep_r.s, prep_r.nmag);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clip span fix-up
  // ---------------------------------------------------------------------------
  always_comb begin
    clip4_nxt.keep = clip3_r.keep;
    clip4_nxt.pos  = clip3_r.pos;
    case (clip3_r.op)
      CLIP_INC: clip4_nxt.ext = sime_pkg::sadd(clip3_r.dif, ONE);
      CLIP_DEC: clip4_nxt.ext = sime_pkg::ssub(clip3_r.dif, ONE);
      default:  clip4_nxt.ext = clip3_r.dif;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Delete and scale datapaths
  // ---------------------------------------------------------------------------
  sime_delete u_delete (
    .clk       (clk),
    .ld        (ld[LAST:3]),
    .pos       (prep_r.t),
    .ext       (prep_r.s),
    .end_fwd   (prep_r.ttp),
    .end_bwd   (prep_r.ttn),
    .reg_start (prep_r.a_d),
    .cnt_m1    (prep_r.nm1),
    .cnt_mag   (prep_r.nmag),
    .cnt_zero  (prep_r.nz),
    .result    (del_res)
  );

  sime_scale #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scale_pos (
    .clk    (clk),
    .ld     (ld[5:3]),
    .neg    (prep_r.dn),
    .mag    (prep_r.dm),
    .factor (scale_factor_r),
    .result (scl_pos)
  );

  sime_scale #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scale_ext (
    .clk    (clk),
    .ld     (ld[5:3]),
    .neg    (prep_r.eneg),
    .mag    (prep_r.emag),
    .factor (scale_factor_r),
    .result (scl_ext)
  );

  // ---------------------------------------------------------------------------
  // Pipeline registers; payload only, valid bits live in the flow unit
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      p1_r <= sime_pkg::word_t'(in_mark_position);
      s1_r <= sime_pkg::word_t'(in_mark_extent);
    end
    if (ld[2]) prep_r <= prep_nxt;
    if (ld[3]) begin
      clip3_r  <= clip3_nxt;
      ins_r[3] <= ins3_nxt;
    end
    if (ld[4]) begin
      clip_r[4] <= clip4_nxt;
      ins_r[4]  <= ins_r[3];
    end
    if (ld[6]) begin
      scl_r[6].keep <= 1'b1;
      scl_r[6].pos  <= scl_pos;
      scl_r[6].ext  <= scl_ext;
    end
    // advance the finished results to the merge stage
    for (int k = 5; k <= LAST; k++) begin
      if (ld[k]) begin
        clip_r[k] <= clip_r[k-1];
        ins_r[k]  <= ins_r[k-1];
      end
    end
    for (int k = 7; k <= LAST; k++) begin
      if (ld[k]) scl_r[k] <= scl_r[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: select by mode, zero a dropped mark, saturate to width
  // ---------------------------------------------------------------------------
  always_comb begin
    case (edit_mode_r)
      sime_pkg::MODE_CLIP:   sel = clip_r[LAST];
      sime_pkg::MODE_DELETE: sel = del_res;
      sime_pkg::MODE_INSERT: sel = ins_r[LAST];
      default:               sel = scl_r[LAST];
    endcase
    keep_nxt = sel.keep;
    pos_nxt  = sel.keep ? clampp(sel.pos) : ZERO;
    ext_nxt  = sel.keep ? clampp(sel.ext) : ZERO;
  end

  always_ff @(posedge clk) begin
    if (ld[sime_pkg::NSTG]) begin
      out_keep_mark_r    <= keep_nxt;
      out_new_position_r <= pos_nxt[POSITION_BITS-1:0];
      out_new_extent_r   <= ext_nxt[POSITION_BITS-1:0];
    end
  end

  assign out_keep_mark    = out_keep_mark_r;
  assign out_new_position = out_new_position_r;
  assign out_new_extent   = out_new_extent_r;

endmodule

### tb/sv/tb_signed_interval_mark_editor_unit.sv
`timescale 1ns / 100ps

// Self-checking bench for the mark editor. Marks stream in through the input
// channel, edited marks come back on the result channel, and each returned
// transaction is compared against a behavioral copy of the edit rules kept
// right here. Registers are reprogrammed only once the pipeline has drained.
module tb_signed_interval_mark_editor_unit;
  import sime_pkg::*;

  typedef longint unsigned u64_t;

  // Saturation limits: 64-bit for the working math, 32-bit for the ports.
  localparam longint L_HI   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint L_LO   = 64'sh8000_0000_0000_0000;
  localparam longint POS_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint POS_LO = -POS_HI - 1;

  localparam int IDLE_PCT = 17;
  localparam int PHASES = 12;
  localparam int PHASE_MARKS = 110;

  typedef enum logic [1:0] {STEP_MARK, STEP_CFG, STEP_DRAIN} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  idx;
    logic [31:0] d0;
    logic [31:0] d1;
  } step_t;

  typedef struct {
    logic        keep;
    logic [31:0] pos;
    logic [31:0] ext;
  } mark_res_t;

  // DUT hookup; every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] in_mark_position = '0;
  logic [31:0] in_mark_extent = '0;
  logic        out_stall = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_wdata = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_keep_mark;
  logic [31:0] out_new_position;
  logic [31:0] out_new_extent;

  // Shadow copy of the edit registers, updated when the DUT sees a write.
  logic [1:0] cur_mode;
  longint     cur_start;
  longint     cur_end;
  longint     cur_count;
  u64_t       cur_factor;

  step_t     work_q[$];
  mark_res_t edited_marks_q[$];

  int        in_flight = 0;
  int        marks_sent = 0;
  int        err_cnt = 0;
  logic      calm;
  logic      nxt_valid;
  logic      nxt_wr;
  step_t     head;
  mark_res_t want;
  mark_res_t got;
  int        delta;

  signed_interval_mark_editor_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mark_position (in_mark_position),
    .in_mark_extent   (in_mark_extent),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_keep_mark    (out_keep_mark),
    .out_new_position (out_new_position),
    .out_new_extent   (out_new_extent),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Edit rules
  // ---------------------------------------------------------------------

  // Exact sum in 65 bits, then pin to the 64-bit range.
  function automatic longint add_sat(longint a, longint b);
    logic signed [64:0] w;
    w = a + b;
    if (w > L_HI) return L_HI;
    if (w < L_LO) return L_LO;
    return w[63:0];
  endfunction

  function automatic longint sub_sat(longint a, longint b);
    logic signed [64:0] w;
    w = a - b;
    if (w > L_HI) return L_HI;
    if (w < L_LO) return L_LO;
    return w[63:0];
  endfunction

  function automatic logic [31:0] fit32(longint v);
    if (v > POS_HI) return 32'h7FFF_FFFF;
    if (v < POS_LO) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Trim against the inclusive window; return 0 to drop the mark.
  function automatic bit clip_mark(inout longint p, inout longint s);
    longint tt;
    if (s == 0) return (p >= cur_start && p <= cur_end);
    if (s > 0) begin
      tt = add_sat(p, s - 1);
      if (tt < cur_start || p > cur_end) return 1'b0;
      if (p < cur_start) begin
        if (tt > cur_end) tt = cur_end;
        p = cur_start;
        s = add_sat(sub_sat(tt, cur_start), 1);
      end else if (tt > cur_end) begin
        s = add_sat(sub_sat(cur_end, p), 1);
      end
      return 1'b1;
    end
    // Backward span: anchor is the last sample, tt the first.
    tt = add_sat(p, s + 1);
    if (p < cur_start || tt > cur_end) return 1'b0;
    if (p > cur_end) begin
      if (tt < cur_start) tt = cur_start;
      p = cur_end;
      s = sub_sat(sub_sat(tt, cur_end), 1);
    end else if (tt < cur_start) begin
      s = sub_sat(sub_sat(cur_start, p), 1);
    end
    return 1'b1;
  endfunction

  // Remove samples a..b; shift, shorten or drop the mark.
  function automatic bit delete_region(inout longint p, inout longint s);
    longint n, a, b, lo, hi, len, s0;
    s0 = s;
    n = cur_count;
    a = cur_start;
    if (n == 0) return 1'b1;
    // Backward delete: normalize the count first, then place the region.
    if (n < 0) begin
      n = sub_sat(0, n);
      a = sub_sat(a, n - 1);
    end
    b = add_sat(a, n - 1);
    if (s0 == 0) begin
      if (p >= a) begin
        if (p <= b) return 1'b0;
        p = sub_sat(p, n);
      end
      return 1'b1;
    end
    if (s0 > 0) begin
      lo = p;
      hi = add_sat(lo, s0 - 1);
      len = s0;
    end else begin
      hi = p;
      lo = add_sat(hi, s0 + 1);
      len = sub_sat(0, s0);
    end
    if (a < lo) begin
      if (b >= hi) return 1'b0;
      if (b < lo) begin
        p = sub_sat(p, n);
        return 1'b1;
      end
      len = sub_sat(len, add_sat(sub_sat(b, lo), 1));
      if (s0 > 0) begin
        s = len;
        p = a;
      end else begin
        s = sub_sat(0, len);
        p = sub_sat(p, n);
      end
      return 1'b1;
    end
    if (a <= hi) begin
      len = sub_sat(len, add_sat(sub_sat((b > hi) ? hi : b, a), 1));
      if (len == 0) return 1'b0;
      if (s0 > 0) begin
        s = len;
      end else begin
        s = sub_sat(0, len);
        p = add_sat(p, add_sat(len, s0));
      end
    end
    return 1'b1;
  endfunction

  // Open a gap of |count| samples at the start point.
  function automatic void insert_region(inout longint p, inout longint s);
    longint n;
    n = cur_count;
    if (n == 0) return;
    if (n < 0) n = sub_sat(0, n);
    if (s == 0) begin
      if (p >= cur_start) p = add_sat(p, n);
    end else if (s > 0) begin
      if (cur_start <= p) p = add_sat(p, n);
      else if (cur_start < add_sat(p, s - 1)) s = add_sat(s, n);
    end else begin
      if (cur_start <= add_sat(p, s + 1)) p = add_sat(p, n);
      else if (cur_start < p) s = sub_sat(s, n);
    end
  endfunction

  // Magnitude times Q16.16, round half away from zero, pin to 32 bits.
  function automatic longint scale_q16(bit neg, u64_t mag, u64_t k);
    u64_t lo_prod, hi_prod, r;
    lo_prod = (mag & 64'hFFFF_FFFF) * k;
    hi_prod = (mag >> 32) * k;
    if (hi_prod >= (64'd1 << 47)) return neg ? POS_LO : POS_HI;
    r = (hi_prod << 16) + ((lo_prod + 64'h8000) >> 16);
    if (!neg) return (r > POS_HI) ? POS_HI : longint'(r);
    if (r > POS_HI) return POS_LO;
    return -longint'(r);
  endfunction

  function automatic mark_res_t edit_mark(logic [31:0] pos, logic [31:0] ext);
    longint    p, s;
    u64_t      mag;
    bit        keep, below;
    mark_res_t r;
    p = $signed(pos);
    s = $signed(ext);
    keep = 1'b1;
    case (cur_mode)
      MODE_CLIP:   keep = clip_mark(p, s);
      MODE_DELETE: keep = delete_region(p, s);
      MODE_INSERT: insert_region(p, s);
      default: begin
        // Scaled offset from the origin; the origin is not added back.
        below = p < cur_start;
        if (below) mag = cur_start - p;
        else mag = p - cur_start;
        p = scale_q16(below, mag, cur_factor);
        if (s < 0) begin
          mag = -s;
          s = scale_q16(1'b1, mag, cur_factor);
        end else begin
          mag = s;
          s = scale_q16(1'b0, mag, cur_factor);
        end
      end
    endcase
    if (!keep) begin
      p = 0;
      s = 0;
    end
    r.keep = keep;
    r.pos = fit32(p);
    r.ext = fit32(s);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus plan
  // ---------------------------------------------------------------------

  task automatic push_mark(input logic [31:0] p, input logic [31:0] e);
    step_t st;
    st.kind = STEP_MARK;
    st.idx = CFG_MODE;
    st.d0 = p;
    st.d1 = e;
    work_q.push_back(st);
  endtask

  task automatic push_cfg(input logic [2:0] idx, input logic [31:0] d);
    step_t st;
    st.kind = STEP_CFG;
    st.idx = idx;
    st.d0 = d;
    st.d1 = '0;
    work_q.push_back(st);
  endtask

  task automatic push_drain();
    step_t st;
    st.kind = STEP_DRAIN;
    st.idx = CFG_MODE;
    st.d0 = '0;
    st.d1 = '0;
    work_q.push_back(st);
  endtask

  // Full-range word, an extreme, or a small value near zero.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom_range(128) - 64;
    endcase
  endfunction

  task automatic plan_phase(input int ph);
    logic [1:0]  mode;
    logic [31:0] w_lo, w_hi, cnt, q16, p, e, base;
    case (ph % 4)
      0: mode = MODE_CLIP;
      1: mode = MODE_DELETE;
      2: mode = MODE_INSERT;
      default: mode = MODE_SCALE;
    endcase
    case ($urandom_range(3))
      0: w_lo = pick_word();
      1: w_lo = $urandom();
      default: w_lo = $urandom_range(2000) - 1000;
    endcase
    // Mostly an end near the start, from 50 below it to 400 above; sometimes anything at all.
    if ($urandom_range(4) == 0) w_hi = pick_word();
    else w_hi = w_lo + $urandom_range(450) - 50;
    case ($urandom_range(4))
      0: cnt = pick_word();
      1: cnt = 32'h0000_0000;
      default: cnt = $urandom_range(600) - 300;
    endcase
    case ($urandom_range(5))
      0: q16 = 32'h0000_0000;
      1: q16 = 32'hFFFF_FFFF;
      2: q16 = SCALE_ONE;
      3: q16 = $urandom();
      default: q16 = $urandom_range(32'h0004_0000, 32'h0000_2000);
    endcase
    // Pin a few phases to the register extremes.
    if (ph == 4) begin
      w_lo = 32'h8000_0000;
      w_hi = 32'h7FFF_FFFF;
    end
    if (ph == 5) cnt = 32'h8000_0000;
    if (ph == 6) cnt = 32'h7FFF_FFFF;
    push_cfg(CFG_MODE, {30'd0, mode});
    push_cfg(CFG_START, w_lo);
    push_cfg(CFG_END, w_hi);
    push_cfg(CFG_COUNT, cnt);
    push_cfg(CFG_SCALE, q16);
    for (int i = 0; i < PHASE_MARKS; i++) begin
      // Hold the sender once until the pipeline is empty.
      if (ph == 3 && i == PHASE_MARKS / 2) push_drain();
      if ($urandom_range(99) < 80) begin
        base = $urandom_range(1) ? w_lo : w_hi;
        p = base + $urandom_range(1000) - 500;
        e = $urandom_range(600) - 300;
      end else begin
        p = pick_word();
        e = pick_word();
      end
      push_mark(p, e);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: advance through the work queue, at most one step per free cycle
  // ---------------------------------------------------------------------

  // Long run with no idling on either side.
  assign calm = (marks_sent >= 600) && (marks_sent < 850);

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_wr_en <= 1'b0;
      marks_sent <= 0;
    end else begin
      nxt_wr = 1'b0;
      if (in_valid && !in_stall) marks_sent <= marks_sent + 1;
      // Hold a stalled transaction; otherwise pick the next step.
      if (!in_valid || !in_stall) begin
        nxt_valid = 1'b0;
        if (work_q.size() != 0) begin
          head = work_q[0];
          case (head.kind)
            STEP_MARK: begin
              // Hold marks back while a register write is on the port.
              if (!cfg_wr_en && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                nxt_valid = 1'b1;
                in_mark_position <= head.d0;
                in_mark_extent <= head.d1;
                void'(work_q.pop_front());
              end
            end
            STEP_CFG: begin
              // Write only with nothing in flight.
              if (!in_valid && in_flight == 0) begin
                nxt_wr = 1'b1;
                cfg_index <= head.idx;
                cfg_wdata <= head.d0;
                void'(work_q.pop_front());
              end
            end
            default: begin
              if (!in_valid && in_flight == 0) void'(work_q.pop_front());
            end
          endcase
        end
        in_valid <= nxt_valid;
      end
      cfg_wr_en <= nxt_wr;
    end
  end

  // Receiver back-pressure, independent of out_valid.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------
  // Monitor: mirror register writes, predict accepted marks, check results
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode <= MODE_CLIP;
      cur_start <= 0;
      cur_end <= 0;
      cur_count <= 0;
      cur_factor <= SCALE_ONE;
      in_flight <= 0;
    end else begin
      delta = 0;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE:  cur_mode <= cfg_wdata[1:0];
          CFG_START: cur_start <= $signed(cfg_wdata);
          CFG_END:   cur_end <= $signed(cfg_wdata);
          CFG_COUNT: cur_count <= $signed(cfg_wdata);
          CFG_SCALE: cur_factor <= cfg_wdata;
          default: ;
        endcase
      end
      // Check the returned transaction first, then queue the new one.
      if (out_valid && !out_stall) begin
        delta = delta - 1;
        got.keep = out_keep_mark;
        got.pos = out_new_position;
        got.ext = out_new_extent;
        if (edited_marks_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10)
            $display("unexpected result: keep %0b pos %0d ext %0d",
                     got.keep, $signed(got.pos), $signed(got.ext));
        end else begin
          want = edited_marks_q.pop_front();
          if (got.keep !== want.keep || got.pos !== want.pos || got.ext !== want.ext) begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= 10)
              $display("mismatch: keep %0b/%0b pos %0d/%0d ext %0d/%0d (exp/act)",
                       want.keep, got.keep, $signed(want.pos), $signed(got.pos),
                       $signed(want.ext), $signed(got.ext));
          end
        end
      end
      if (in_valid && !in_stall) begin
        delta = delta + 1;
        edited_marks_q.push_back(edit_mark(in_mark_position, in_mark_extent));
      end
      in_flight <= in_flight + delta;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed marks, random phases, drain, verdict
  // ---------------------------------------------------------------------

  initial begin
    // Clip to -100..100: edges, trims on both ends, backward spans, extremes.
    push_cfg(CFG_MODE, {30'd0, MODE_CLIP});
    push_cfg(CFG_START, -100);
    push_cfg(CFG_END, 100);
    push_mark(-100, 0);
    push_mark(101, 0);
    push_mark(-150, 100);
    push_mark(50, 100);
    push_mark(150, -100);
    push_mark(0, -200);
    push_mark(32'h8000_0000, 32'h7FFF_FFFF);
    push_mark(32'h7FFF_FFFF, 32'h8000_0000);
    // Reversed window drops everything.
    push_cfg(CFG_START, 10);
    push_cfg(CFG_END, -10);
    push_mark(0, 0);
    push_mark(0, 5);
    // Backward delete of ten samples ending at 20.
    push_cfg(CFG_MODE, {30'd0, MODE_DELETE});
    push_cfg(CFG_START, 20);
    push_cfg(CFG_COUNT, -10);
    push_mark(15, 0);
    push_mark(30, 0);
    push_mark(5, 20);
    push_mark(25, -20);
    push_mark(12, 4);
    // Insert with a negative count: magnitude only.
    push_cfg(CFG_MODE, {30'd0, MODE_INSERT});
    push_cfg(CFG_COUNT, -7);
    push_mark(20, 0);
    push_mark(10, 20);
    push_mark(30, -15);
    push_mark(19, 0);
    // Scale by one half: rounding ties go away from zero.
    push_cfg(CFG_MODE, {30'd0, MODE_SCALE});
    push_cfg(CFG_START, 0);
    push_cfg(CFG_SCALE, 32'h0000_8000);
    push_mark(3, -3);
    push_mark(-5, 1);
    // Largest factor from the lowest origin saturates both fields of the first mark.
    push_cfg(CFG_START, 32'h8000_0000);
    push_cfg(CFG_SCALE, 32'hFFFF_FFFF);
    push_mark(32'h7FFF_FFFF, 32'h8000_0000);
    push_mark(32'h8000_0000, 32'h7FFF_FFFF);
    push_cfg(CFG_SCALE, 32'h0000_0000);
    push_mark(1234, -77);

    for (int ph = 0; ph < PHASES; ph++) plan_phase(ph);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the queue to empty and the last result to come back.
    while (work_q.size() != 0 || in_valid || in_flight != 0) @(posedge clk);
    repeat (NSTG + 8) @(posedge clk);
    if (edited_marks_q.size() != 0) begin
      $display("%0d results never arrived", edited_marks_q.size());
      err_cnt = err_cnt + edited_marks_q.size();
    end
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #800_000;
    $display("watchdog expired");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
